// ===== design/vlpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vlpd_pkg
// shared types and constants of the varint length prefixed deframer
// ----------------------------------------------------------------------------
`default_nettype none

package vlpd_pkg;

    localparam int STATUS_W  = 2;
    localparam int HDR_CNT_W = 4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;

    // longest header a 64 bit varint can have
    localparam logic [HDR_CNT_W-1:0] VARINT_MAX_BYTES = 4'd10;

    localparam logic [31:0] MAX_LEN_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                byte_valid;
        logic                frame_last;
        logic                empty_frame;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

// ===== design/vlpd_in_reg.sv =====
// ----------------------------------------------------------------------------
// vlpd_in_reg
// input register stage for the raw byte stream
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // data_byte
    input  wire logic       advance,
    output logic            in_vld,
    output logic [7:0]      in_byte
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;

    assign s_tready = !vld_reg || advance;
    assign vld_next = s_tready ? s_tvalid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign in_vld  = vld_reg;
    assign in_byte = byte_reg;

endmodule

`default_nettype wire

// ===== design/vlpd_core.sv =====
// ----------------------------------------------------------------------------
// vlpd_core
// header gathering, length checks and payload counting, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_core #(
    parameter int HEADER_BYTES = 10,
    parameter int LEN_BITS     = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] max_frame_length,
    output logic             res_vld,
    output vlpd_pkg::result_t res
);

    import vlpd_pkg::*;

    localparam int ACC_BITS = (7 * HEADER_BYTES > 64) ? 64 : 7 * HEADER_BYTES;
    localparam logic [HDR_CNT_W-1:0] HDR_LIMIT = HDR_CNT_W'(HEADER_BYTES);
    localparam logic [63:0] LEN_MASK =
        (LEN_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LEN_BITS) - 64'd1);

    logic                 failed_reg,     failed_next;
    logic                 in_payload_reg, in_payload_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg,    hdr_cnt_next;
    logic [ACC_BITS-1:0]  acc_reg,        acc_next;
    logic [LEN_BITS-1:0]  remain_reg,     remain_next;

    logic [ACC_BITS+6:0]  grp_shift;
    logic [ACC_BITS-1:0]  acc_new;
    logic [63:0]          acc_wide;
    logic [LEN_BITS-1:0]  remain_dec;
    logic [LEN_BITS-1:0]  new_len;
    logic                 more;
    logic                 bad_hdr;
    logic                 too_large;

    assign more      = data_byte[7];
    assign grp_shift = {{ACC_BITS{1'b0}}, data_byte[6:0]} << ({3'b000, hdr_cnt_reg} * 7'd7);
    assign acc_new   = acc_reg | grp_shift[ACC_BITS-1:0];
    assign acc_wide  = 64'(acc_new);
    assign new_len   = LEN_BITS'(acc_wide);
    assign remain_dec = remain_reg - LEN_BITS'(1);

    // header checks in the order the decoder applies them
    assign bad_hdr =
        (hdr_cnt_reg >= VARINT_MAX_BYTES) || (hdr_cnt_reg >= HDR_LIMIT) ||
        ((hdr_cnt_reg == VARINT_MAX_BYTES - 4'd1) && (data_byte[6:1] != 6'd0)) ||
        (more && ((hdr_cnt_reg + 4'd1) >= HDR_LIMIT)) ||
        (!more && (hdr_cnt_reg != 4'd0) && (data_byte == 8'd0));

    assign too_large = (acc_wide > {32'd0, max_frame_length}) || (acc_wide > LEN_MASK);

    always_comb
    begin
        failed_next     = failed_reg;
        in_payload_next = in_payload_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        acc_next        = acc_reg;
        remain_next     = remain_reg;
        res_vld         = 1'b0;
        res             = '{payload_byte: 8'd0, byte_valid: 1'b0, frame_last: 1'b0,
                            empty_frame: 1'b0, status: ST_OK};
        if (step && !failed_reg)
        begin
            if (in_payload_reg)
            begin
                remain_next      = remain_dec;
                res_vld          = 1'b1;
                res.payload_byte = data_byte;
                res.byte_valid   = 1'b1;
                if (remain_dec == '0)
                begin
                    in_payload_next = 1'b0;
                    res.frame_last  = 1'b1;
                end
            end
            else if (bad_hdr || (!more && too_large))
            begin
                failed_next     = 1'b1;
                in_payload_next = 1'b0;
                remain_next     = '0;
                hdr_cnt_next    = '0;
                acc_next        = '0;
                res_vld         = 1'b1;
                res.status      = bad_hdr ? ST_MALFORMED : ST_TOO_LARGE;
            end
            else if (more)
            begin
                acc_next     = acc_new;
                hdr_cnt_next = hdr_cnt_reg + 4'd1;
            end
            else
            begin
                remain_next  = new_len;
                hdr_cnt_next = '0;
                acc_next     = '0;
                if (new_len == '0)
                begin
                    res_vld         = 1'b1;
                    res.frame_last  = 1'b1;
                    res.empty_frame = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg     <= 1'b0;
            in_payload_reg <= 1'b0;
            hdr_cnt_reg    <= '0;
            acc_reg        <= '0;
            remain_reg     <= '0;
        end
        else
        begin
            failed_reg     <= failed_next;
            in_payload_reg <= in_payload_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            acc_reg        <= acc_next;
            remain_reg     <= remain_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/vlpd_out_reg.sv =====
// ----------------------------------------------------------------------------
// vlpd_out_reg
// result register driving the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic              res_vld,
    input  vlpd_pkg::result_t      res,
    output logic                   advance,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,    // payload_byte
    output logic                   m_tlast,    // frame_last
    output logic [3:0]             m_tuser     // byte_valid, empty_frame, status[1:0]
);

    import vlpd_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign advance  = !vld_reg || m_tready;
    assign vld_next = advance ? (take && res_vld) : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && take && res_vld)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tlast  = res_reg.frame_last;
    assign m_tuser  = {res_reg.status, res_reg.empty_frame, res_reg.byte_valid};

endmodule

`default_nettype wire

// ===== design/varint_length_prefixed_deframer_top.sv =====
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer_top
// splits a byte stream of varint length prefixed frames into payload words
// ----------------------------------------------------------------------------
// registers: each input word is held in the input register, its result word in the result register
// throughput: one input word per cycle while the output is not stalled, header state and
//   payload count update in a single pass between the input and result registers
// reset: asynchronous, active low; clears the decoder and the error latch,
//   max_frame_length returns to all ones
// ----------------------------------------------------------------------------
`default_nettype none

module varint_length_prefixed_deframer_top #(
    parameter int HEADER_BYTES = 10,
    parameter int LEN_BITS     = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,   // max_frame_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,       // payload_byte
    output logic             m_tlast,       // frame_last
    output logic [3:0]       m_tuser        // byte_valid, empty_frame, status[1:0]
);

    import vlpd_pkg::*;

    logic [31:0] max_len_reg;
    logic [31:0] max_len_next;
    logic        advance;
    logic        in_vld;
    logic [7:0]  in_byte;
    logic        res_vld;
    result_t     res;

    // zero means no limit
    assign max_len_next = cfg_wr_en ?
        ((cfg_wr_data == 32'd0) ? MAX_LEN_RESET : cfg_wr_data) : max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    vlpd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_vld   (in_vld),
        .in_byte  (in_byte)
    );

    vlpd_core #(
        .HEADER_BYTES (HEADER_BYTES),
        .LEN_BITS     (LEN_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (in_vld && advance),
        .data_byte        (in_byte),
        .max_frame_length (max_len_reg),
        .res_vld          (res_vld),
        .res              (res)
    );

    vlpd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (in_vld),
        .res_vld  (res_vld),
        .res      (res),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // a word is either payload or an empty frame marker, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("payload word flagged as empty frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("empty frame without last");

    // error words carry nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[3:2] != ST_OK)) |->
            (m_tdata == 8'd0 && !m_tlast && !m_tuser[0] && !m_tuser[1]))
        else $error("error word carries data");

    // an error is the last word until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && (m_tuser[3:2] != ST_OK)) |=> !m_tvalid)
        else $error("word after error");

endmodule

`default_nettype wire
